// File: hw/rtl/irdi_pkg.sv
`timescale 1ns / 1ps
package irdi_pkg;

    localparam int NUM_SENSORS  = 16;
    localparam int SENSOR_X_POS = 0;
    localparam int SENSOR_Y_NEG = NUM_SENSORS / 4;
    localparam int SENSOR_X_NEG = NUM_SENSORS / 2;
    localparam int SENSOR_Y_POS = NUM_SENSORS * 3 / 4;

    localparam int TICK_W   = 8;
    localparam logic [TICK_W-1:0] WINDOW_RESET = 8'd100;
    localparam int TOTAL_W  = 12;
    localparam int DEG_W    = 8;
    localparam int DIR_W    = DEG_W + 1;
    localparam int DEG_MAX  = 180;

    // cos/sin of d * 3.141592 / 180 in signed Q50
    localparam int TRIG_FRAC = 50;
    localparam int TRIG_W    = TRIG_FRAC + 2;
    localparam int WORK_FRAC = 62;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } trig_t;

    typedef trig_t [DEG_MAX:0] trig_tab_t;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic zero;
    } irdi_flags_t;

    // step angle by Taylor series, then repeated rotation at Q62
    function automatic trig_tab_t build_trig_tab();
        trig_tab_t tab;
        logic signed [127:0] one;
        logic signed [127:0] half;
        logic signed [127:0] dlt;
        logic signed [127:0] p2;
        logic signed [127:0] p3;
        logic signed [127:0] p4;
        logic signed [127:0] p5;
        logic signed [127:0] p6;
        logic signed [127:0] p7;
        logic signed [127:0] p8;
        logic signed [127:0] sd;
        logic signed [127:0] cd;
        logic signed [127:0] c;
        logic signed [127:0] s;
        logic signed [127:0] cn;
        int n;
        one  = 128'sd1 <<< WORK_FRAC;
        half = 128'sd1 <<< (WORK_FRAC - TRIG_FRAC - 1);
        dlt  = (128'sd392699 <<< WORK_FRAC) / 128'sd22500000;
        p2   = (dlt * dlt) >>> WORK_FRAC;
        p3   = (p2 * dlt) >>> WORK_FRAC;
        p4   = (p3 * dlt) >>> WORK_FRAC;
        p5   = (p4 * dlt) >>> WORK_FRAC;
        p6   = (p5 * dlt) >>> WORK_FRAC;
        p7   = (p6 * dlt) >>> WORK_FRAC;
        p8   = (p7 * dlt) >>> WORK_FRAC;
        sd   = dlt - p3 / 128'sd6 + p5 / 128'sd120 - p7 / 128'sd5040;
        cd   = one - p2 / 128'sd2 + p4 / 128'sd24 - p6 / 128'sd720 + p8 / 128'sd40320;
        c    = one;
        s    = '0;
        for (n = 0; n <= DEG_MAX; n++)
        begin
            tab[n].c = TRIG_W'((c + half) >>> (WORK_FRAC - TRIG_FRAC));
            tab[n].s = TRIG_W'((s + half) >>> (WORK_FRAC - TRIG_FRAC));
            cn = (c * cd - s * sd) >>> WORK_FRAC;
            s  = (s * cd + c * sd) >>> WORK_FRAC;
            c  = cn;
        end
        return tab;
    endfunction

    localparam trig_tab_t TRIG_TAB = build_trig_tab();

endpackage

// File: hw/rtl/irdi_fifo.sv
`timescale 1ns / 1ps
module irdi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/irdi_front.sv
`timescale 1ns / 1ps
module irdi_front
    import irdi_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sensor_valid,
    output logic                   sensor_ready,
    input  logic [NUM_SENSORS-1:0] sensor_levels,
    input  logic                   cfg_wr_en,
    input  logic [TICK_W-1:0]      cfg_wr_data,
    output logic                   push,
    input  logic                   queue_full,
    output logic [COUNT_WIDTH-1:0] mag_y,
    output logic [COUNT_WIDTH-1:0] mag_x,
    output irdi_flags_t            flags,
    output logic [TOTAL_W-1:0]     total
);

    localparam int HALF   = NUM_SENSORS / 2;
    localparam int HALF_W = $clog2(HALF + 1);

    logic [TICK_W-1:0]      window_reg, window_next;
    logic [TICK_W-1:0]      tick_reg, tick_next, tick_inc;
    logic [COUNT_WIDTH-1:0] xp_reg, xp_next, xp_inc;
    logic [COUNT_WIDTH-1:0] xn_reg, xn_next, xn_inc;
    logic [COUNT_WIDTH-1:0] yp_reg, yp_next, yp_inc;
    logic [COUNT_WIDTH-1:0] yn_reg, yn_next, yn_inc;
    logic [TOTAL_W-1:0]     total_reg, total_next, total_inc;
    logic [NUM_SENSORS-1:0] hits;
    logic [HALF_W-1:0]      pop_lo, pop_hi;
    logic signed [COUNT_WIDTH:0] diff_y, diff_x;
    logic                   close, accept;

    assign hits = ~sensor_levels;

    always_comb
    begin
        pop_lo = '0;
        pop_hi = '0;
        for (int i = 0; i < HALF; i++)
        begin
            pop_lo = pop_lo + HALF_W'(hits[i]);
            pop_hi = pop_hi + HALF_W'(hits[HALF + i]);
        end
    end

    assign tick_inc  = tick_reg + 1'b1;
    assign close     = (tick_inc >= window_reg);
    assign sensor_ready = !queue_full || !close;
    assign accept    = sensor_valid && sensor_ready;
    assign push      = accept && close;

    assign xp_inc    = xp_reg + COUNT_WIDTH'(hits[SENSOR_X_POS]);
    assign xn_inc    = xn_reg + COUNT_WIDTH'(hits[SENSOR_X_NEG]);
    assign yp_inc    = yp_reg + COUNT_WIDTH'(hits[SENSOR_Y_POS]);
    assign yn_inc    = yn_reg + COUNT_WIDTH'(hits[SENSOR_Y_NEG]);
    assign total_inc = total_reg + TOTAL_W'(pop_lo) + TOTAL_W'(pop_hi);

    assign diff_y = $signed({1'b0, yp_inc}) - $signed({1'b0, yn_inc});
    assign diff_x = $signed({1'b0, xp_inc}) - $signed({1'b0, xn_inc});

    assign mag_y       = diff_y[COUNT_WIDTH] ? COUNT_WIDTH'(-diff_y) : diff_y[COUNT_WIDTH-1:0];
    assign mag_x       = diff_x[COUNT_WIDTH] ? COUNT_WIDTH'(-diff_x) : diff_x[COUNT_WIDTH-1:0];
    assign flags.y_neg = diff_y[COUNT_WIDTH];
    assign flags.x_neg = diff_x[COUNT_WIDTH];
    assign flags.zero  = (diff_y == '0) && (diff_x == '0);
    assign total       = total_inc;

    always_comb
    begin
        window_next = cfg_wr_en ? cfg_wr_data : window_reg;
        tick_next   = tick_reg;
        xp_next     = xp_reg;
        xn_next     = xn_reg;
        yp_next     = yp_reg;
        yn_next     = yn_reg;
        total_next  = total_reg;
        if (accept)
        begin
            if (close)
            begin
                tick_next  = '0;
                xp_next    = '0;
                xn_next    = '0;
                yp_next    = '0;
                yn_next    = '0;
                total_next = '0;
            end
            else
            begin
                tick_next  = tick_inc;
                xp_next    = xp_inc;
                xn_next    = xn_inc;
                yp_next    = yp_inc;
                yn_next    = yn_inc;
                total_next = total_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            tick_reg   <= '0;
            xp_reg     <= '0;
            xn_reg     <= '0;
            yp_reg     <= '0;
            yn_reg     <= '0;
            total_reg  <= '0;
        end
        else
        begin
            window_reg <= window_next;
            tick_reg   <= tick_next;
            xp_reg     <= xp_next;
            xn_reg     <= xn_next;
            yp_reg     <= yp_next;
            yn_reg     <= yn_next;
            total_reg  <= total_next;
        end
    end

endmodule

// File: hw/rtl/irdi_back.sv
`timescale 1ns / 1ps
module irdi_back
    import irdi_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    entry_valid,
    output logic                    entry_pop,
    input  logic [COUNT_WIDTH-1:0]  mag_y,
    input  logic [COUNT_WIDTH-1:0]  mag_x,
    input  irdi_flags_t             flags,
    input  logic [TOTAL_W-1:0]      total,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic signed [DIR_W-1:0] direction_deg,
    output logic [TOTAL_W-1:0]      total_hits
);

    localparam int ACC_W  = TRIG_W + COUNT_WIDTH + 1;
    localparam int STEP_W = (COUNT_WIDTH > 1) ? $clog2(COUNT_WIDTH) : 1;
    localparam int BIT_W  = $clog2(DEG_W);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_MAC    = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [COUNT_WIDTH-1:0]   ay_reg, ay_next;
    logic [COUNT_WIDTH-1:0]   ax_reg, ax_next;
    irdi_flags_t              flags_reg, flags_next;
    logic [TOTAL_W-1:0]       total_reg, total_next;
    logic [DEG_W-1:0]         deg_reg, deg_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [COUNT_WIDTH-1:0]   ay_sh_reg, ay_sh_next;
    logic [COUNT_WIDTH-1:0]   ax_sh_reg, ax_sh_next;
    logic signed [TRIG_W-1:0] c_reg, c_next;
    logic signed [TRIG_W-1:0] st_reg, st_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DIR_W-1:0]  out_dir_reg, out_dir_next;
    logic [TOTAL_W-1:0]       out_total_reg, out_total_next;

    logic [DEG_W-1:0]         cand, tab_idx;
    logic                     in_range;
    trig_t                    tab_entry;
    logic signed [ACC_W-1:0]  c_add, s_add, acc_mac;
    logic signed [DIR_W-1:0]  dir_mag, dir_val;

    assign cand      = deg_reg | (DEG_W'(1) << bit_reg);
    assign in_range  = (cand <= DEG_W'(DEG_MAX));
    assign tab_idx   = in_range ? cand : DEG_W'(DEG_MAX);
    assign tab_entry = TRIG_TAB[tab_idx];

    // cross product cos*|y| - sin*x, one bit of each magnitude per cycle
    assign c_add   = ay_sh_reg[COUNT_WIDTH-1] ? ACC_W'(c_reg) : '0;
    assign s_add   = ax_sh_reg[COUNT_WIDTH-1] ? ACC_W'(st_reg) : '0;
    assign acc_mac = (acc_reg <<< 1) + c_add + s_add;

    assign dir_mag = $signed({1'b0, deg_reg});
    assign dir_val = flags_reg.zero  ? '0 :
                     flags_reg.y_neg ? -dir_mag : dir_mag;

    assign result_valid  = out_valid_reg;
    assign direction_deg = out_dir_reg;
    assign total_hits    = out_total_reg;

    always_comb
    begin
        state_next     = state_reg;
        ay_next        = ay_reg;
        ax_next        = ax_reg;
        flags_next     = flags_reg;
        total_next     = total_reg;
        deg_next       = deg_reg;
        bit_next       = bit_reg;
        step_next      = step_reg;
        ay_sh_next     = ay_sh_reg;
        ax_sh_next     = ax_sh_reg;
        c_next         = c_reg;
        st_next        = st_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_dir_next   = out_dir_reg;
        out_total_next = out_total_reg;
        entry_pop      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (entry_valid)
                begin
                    entry_pop  = 1'b1;
                    ay_next    = mag_y;
                    ax_next    = mag_x;
                    flags_next = flags;
                    total_next = total;
                    deg_next   = '0;
                    bit_next   = BIT_W'(DEG_W - 1);
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!in_range)
                begin
                    if (bit_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        bit_next = bit_reg - 1'b1;
                    end
                end
                else
                begin
                    c_next     = tab_entry.c;
                    st_next    = flags_reg.x_neg ? tab_entry.s : -tab_entry.s;
                    acc_next   = '0;
                    ay_sh_next = ay_reg;
                    ax_sh_next = ax_reg;
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                acc_next   = acc_mac;
                ay_sh_next = ay_sh_reg << 1;
                ax_sh_next = ax_sh_reg << 1;
                step_next  = step_reg + 1'b1;
                if (step_reg == STEP_W'(COUNT_WIDTH - 1))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!acc_reg[ACC_W-1])
                begin
                    deg_next = cand;
                end
                if (bit_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_dir_next   = dir_val;
                    out_total_next = total_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ay_reg        <= ay_next;
        ax_reg        <= ax_next;
        flags_reg     <= flags_next;
        total_reg     <= total_next;
        deg_reg       <= deg_next;
        bit_reg       <= bit_next;
        step_reg      <= step_next;
        ay_sh_reg     <= ay_sh_next;
        ax_sh_reg     <= ax_sh_next;
        c_reg         <= c_next;
        st_reg        <= st_next;
        acc_reg       <= acc_next;
        out_dir_reg   <= out_dir_next;
        out_total_reg <= out_total_next;
    end

endmodule

// File: hw/rtl/ir_ring_direction_integrator.sv
`timescale 1ns / 1ps
// Throughput: one tick request per cycle, except that a window-closing tick stalls while the
//   queue is full; ticks keep flowing while a bearing is computed. Result path: a
//   window-closing tick queues an entry whose result is set by the bit-serial cross-product
//   unit that tests eight candidate angles; a new result can start once the previous one is done.
// Reset: rst_n asynchronous active low; clears counters, queue and output valid,
//   window length returns to 100.
module ir_ring_direction_integrator
    import irdi_pkg::*;
#(
    parameter int COUNT_WIDTH = 8,
    parameter int QUEUE_DEPTH = 2
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sensor_valid,
    output logic                    sensor_ready,
    input  logic [NUM_SENSORS-1:0]  sensor_levels,
    input  logic                    cfg_wr_en,
    input  logic [TICK_W-1:0]       cfg_wr_data,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic signed [DIR_W-1:0] direction_deg,
    output logic [TOTAL_W-1:0]      total_hits
);

    localparam int ENTRY_W = 2 * COUNT_WIDTH + $bits(irdi_flags_t) + TOTAL_W;

    logic                   push, queue_full, queue_empty, pop;
    logic [COUNT_WIDTH-1:0] f_mag_y, f_mag_x, q_mag_y, q_mag_x;
    irdi_flags_t            f_flags, q_flags;
    logic [TOTAL_W-1:0]     f_total, q_total;
    logic [ENTRY_W-1:0]     push_data, pop_data;

    irdi_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .sensor_valid  (sensor_valid),
        .sensor_ready  (sensor_ready),
        .sensor_levels (sensor_levels),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .push          (push),
        .queue_full    (queue_full),
        .mag_y         (f_mag_y),
        .mag_x         (f_mag_x),
        .flags         (f_flags),
        .total         (f_total)
    );

    assign push_data = {f_mag_y, f_mag_x, f_flags, f_total};

    irdi_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    assign {q_mag_y, q_mag_x, q_flags, q_total} = pop_data;

    irdi_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .entry_valid   (!queue_empty),
        .entry_pop     (pop),
        .mag_y         (q_mag_y),
        .mag_x         (q_mag_x),
        .flags         (q_flags),
        .total         (q_total),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .direction_deg (direction_deg),
        .total_hits    (total_hits)
    );

endmodule

// File: hw/rtl/irdi_checker.sv
`timescale 1ns / 1ps
module irdi_checker
    import irdi_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    sensor_valid,
    input logic                    sensor_ready,
    input logic [NUM_SENSORS-1:0]  sensor_levels,
    input logic                    cfg_wr_en,
    input logic [TICK_W-1:0]       cfg_wr_data,
    input logic                    result_valid,
    input logic                    result_ready,
    input logic signed [DIR_W-1:0] direction_deg,
    input logic [TOTAL_W-1:0]      total_hits
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(direction_deg) && $stable(total_hits))
        else $error("result changed while stalled");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (direction_deg <= 9'sd180) && (direction_deg >= -9'sd180))
        else $error("bearing out of range");

    // no hits means both differences are zero
    a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (total_hits == '0) |-> (direction_deg == '0))
        else $error("bearing nonzero for empty window");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

endmodule

bind ir_ring_direction_integrator irdi_checker u_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import irdi_pkg::*;

    localparam int   CLK_HALF   = 6;
    localparam int   IDLE_PCT   = 8;
    localparam int   CALM_START = 4000;
    localparam int   CALM_END   = 7000;
    localparam int   SETTLE     = 100;
    localparam int   RAND_TICKS = 480;
    localparam int   MAX_SHOWN  = 10;
    localparam int   LIMIT_NS   = 10_000_000;
    localparam int   PCT_SET [5] = '{0, 20, 50, 80, 100};

    typedef enum logic [1:0] {REQ_TICK, REQ_CFG, REQ_DRAIN} req_kind_e;

    typedef struct {
        req_kind_e   kind;
        logic [15:0] data;
    } req_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir;
        logic [TOTAL_W-1:0]      total;
    } bearing_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    sensor_valid = 1'b0;
    logic                    sensor_ready;
    logic [NUM_SENSORS-1:0]  sensor_levels = '1;
    logic                    cfg_wr_en = 1'b0;
    logic [TICK_W-1:0]       cfg_wr_data = '0;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    logic signed [DIR_W-1:0] direction_deg;
    logic [TOTAL_W-1:0]      total_hits;

    req_t     tick_reqs[$];
    bearing_t pending_bearings[$];

    logic [7:0]        hit_cnt [NUM_SENSORS];
    logic [TICK_W-1:0] tick_cnt;
    logic [TICK_W-1:0] win_len;

    int  cyc;
    int  quiet;
    int  err_cnt;
    int  n_ticks;
    int  n_checked;
    int  n_cfg;
    bit  calm;

    ir_ring_direction_integrator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sensor_valid  (sensor_valid),
        .sensor_ready  (sensor_ready),
        .sensor_levels (sensor_levels),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .direction_deg (direction_deg),
        .total_hits    (total_hits)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    assign calm = (cyc >= CALM_START) && (cyc < CALM_END);

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
            $display("%s", msg);
    endtask

    function automatic logic signed [DIR_W-1:0] bearing_deg(input int dy, input int dx);
        real deg;
        if (dy == 0 && dx == 0)
            return '0;
        deg = $atan2(real'(dy), real'(dx)) * 180.0 / 3.141592;
        return DIR_W'($rtoi(deg));
    endfunction

    task automatic integrate_tick(input logic [NUM_SENSORS-1:0] lv);
        bearing_t           b;
        logic [TOTAL_W-1:0] sum;
        int                 dy;
        int                 dx;
        for (int i = 0; i < NUM_SENSORS; i++)
            if (!lv[i])
                hit_cnt[i] = hit_cnt[i] + 8'd1;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= win_len)
        begin
            tick_cnt = '0;
            dy = int'(hit_cnt[SENSOR_Y_POS]) - int'(hit_cnt[SENSOR_Y_NEG]);
            dx = int'(hit_cnt[SENSOR_X_POS]) - int'(hit_cnt[SENSOR_X_NEG]);
            sum = '0;
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                sum = sum + TOTAL_W'(hit_cnt[i]);
                hit_cnt[i] = '0;
            end
            b.dir = bearing_deg(dy, dx);
            b.total = sum;
            pending_bearings.push_back(b);
        end
    endtask

    task automatic add_req(input req_kind_e kind, input logic [15:0] data);
        req_t r;
        r.kind = kind;
        r.data = data;
        tick_reqs.push_back(r);
    endtask

    // one window of ticks, each ring axis sensor hit with its own probability
    task automatic add_window(input int wl, output int added);
        int                     pct [4];
        int                     key [4];
        logic [NUM_SENSORS-1:0] lv;
        key = '{SENSOR_X_POS, SENSOR_Y_NEG, SENSOR_X_NEG, SENSOR_Y_POS};
        foreach (pct[k])
            pct[k] = PCT_SET[$urandom_range(0, 4)];
        added = (wl == 0) ? 1 : wl;
        for (int t = 0; t < added; t++)
        begin
            lv = NUM_SENSORS'($urandom);
            foreach (key[k])
                lv[key[k]] = ($urandom_range(0, 99) < pct[k]) ? 1'b0 : 1'b1;
            add_req(REQ_TICK, lv);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        logic                   nv;
        logic [NUM_SENSORS-1:0] nl;
        logic                   nw;
        logic [TICK_W-1:0]      nd;
        if (!rst_n)
        begin
            sensor_valid <= 1'b0;
            cfg_wr_en    <= 1'b0;
            quiet        <= 0;
        end
        else
        begin
            nv = sensor_valid;
            nl = sensor_levels;
            nw = 1'b0;
            nd = cfg_wr_data;
            if (sensor_valid && sensor_ready)
            begin
                integrate_tick(sensor_levels);
                n_ticks++;
                nv = 1'b0;
                quiet = 0;
            end
            else if (pending_bearings.size() != 0)
                quiet = 0;
            else if (quiet < SETTLE)
                quiet++;
            if (!nv && tick_reqs.size() != 0)
            begin
                case (tick_reqs[0].kind)
                    REQ_TICK:
                    begin
                        if (calm || $urandom_range(0, 99) >= IDLE_PCT)
                        begin
                            nv = 1'b1;
                            nl = tick_reqs[0].data;
                            void'(tick_reqs.pop_front());
                        end
                    end
                    REQ_CFG:
                    begin
                        if (quiet >= SETTLE)
                        begin
                            nw = 1'b1;
                            nd = tick_reqs[0].data[TICK_W-1:0];
                            win_len = nd;
                            n_cfg++;
                            quiet = 0;
                            void'(tick_reqs.pop_front());
                        end
                    end
                    REQ_DRAIN:
                    begin
                        if (pending_bearings.size() == 0)
                            void'(tick_reqs.pop_front());
                    end
                    default:
                        void'(tick_reqs.pop_front());
                endcase
            end
            sensor_valid  <= nv;
            sensor_levels <= nl;
            cfg_wr_en     <= nw;
            cfg_wr_data   <= nd;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        bearing_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_bearings.size() == 0)
                    flag_error($sformatf("unexpected result: dir %0d total %0d",
                                         direction_deg, total_hits));
                else
                begin
                    want = pending_bearings.pop_front();
                    n_checked++;
                    if (direction_deg !== want.dir || total_hits !== want.total)
                        flag_error($sformatf(
                            "mismatch: dir exp %0d got %0d, total exp %0d got %0d",
                            want.dir, direction_deg, want.total, total_hits));
                end
            end
            result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("[ir_ring_direction_integrator] ERROR");
        $finish;
    end

    initial
    begin
        int added;
        int n_rand;
        int wl;
        int phase;
        logic [NUM_SENSORS-1:0] lv;

        rst_n <= 1'b0;
        cyc = 0;
        err_cnt = 0;
        n_ticks = 0;
        n_checked = 0;
        n_cfg = 0;
        tick_cnt = '0;
        win_len = WINDOW_RESET;
        foreach (hit_cnt[i])
            hit_cnt[i] = '0;

        // reset window length first
        for (int t = 0; t < WINDOW_RESET; t++)
            add_req(REQ_TICK, NUM_SENSORS'($urandom));

        // single-tick windows: each axis, quadrant, the null and opposite cases
        add_req(REQ_CFG, 16'd1);
        add_req(REQ_TICK, 16'hFFFF);
        add_req(REQ_TICK, 16'h0000);
        add_req(REQ_TICK, ~(16'd1 << SENSOR_X_POS));
        add_req(REQ_TICK, ~(16'd1 << SENSOR_X_NEG));
        add_req(REQ_TICK, ~(16'd1 << SENSOR_Y_POS));
        add_req(REQ_TICK, ~(16'd1 << SENSOR_Y_NEG));
        add_req(REQ_TICK, ~((16'd1 << SENSOR_X_POS) | (16'd1 << SENSOR_Y_POS)));
        add_req(REQ_TICK, ~((16'd1 << SENSOR_X_NEG) | (16'd1 << SENSOR_Y_POS)));
        add_req(REQ_TICK, ~((16'd1 << SENSOR_X_NEG) | (16'd1 << SENSOR_Y_NEG)));
        add_req(REQ_TICK, ~((16'd1 << SENSOR_X_POS) | (16'd1 << SENSOR_Y_NEG)));
        add_req(REQ_TICK, 16'h5555);
        add_req(REQ_TICK, 16'hAAAA);

        add_req(REQ_CFG, 16'd2);
        add_req(REQ_TICK, ~((16'd1 << SENSOR_X_POS) | (16'd1 << SENSOR_Y_POS)));
        add_req(REQ_TICK, ~(16'd1 << SENSOR_X_POS));

        // zero window length behaves as one
        add_req(REQ_CFG, 16'd0);
        for (int t = 0; t < 3; t++)
            add_req(REQ_TICK, NUM_SENSORS'($urandom));

        // window lowered below the ticks already counted
        add_req(REQ_CFG, 16'd50);
        for (int t = 0; t < 30; t++)
            add_req(REQ_TICK, NUM_SENSORS'($urandom));
        add_req(REQ_CFG, 16'd10);
        add_req(REQ_TICK, NUM_SENSORS'($urandom));

        // longest window: full counters, then bearing next to -180
        add_req(REQ_CFG, 16'd255);
        for (int t = 0; t < 255; t++)
            add_req(REQ_TICK, 16'h0000);
        for (int t = 0; t < 255; t++)
        begin
            lv = ~(16'd1 << SENSOR_X_NEG);
            if (t == 100)
                lv[SENSOR_Y_NEG] = 1'b0;
            add_req(REQ_TICK, lv);
        end

        n_rand = 0;
        phase = 0;
        while (n_rand < RAND_TICKS)
        begin
            case ($urandom_range(0, 99)) inside
                [0:1]:   wl = 0;
                [2:74]:  wl = $urandom_range(1, 8);
                default: wl = $urandom_range(9, 40);
            endcase
            add_req(REQ_CFG, 16'(wl));
            repeat ($urandom_range(1, 5))
            begin
                add_window(wl, added);
                n_rand += added;
            end
            // stray ticks leave a partial window for the next setting
            if ($urandom_range(0, 9) < 3)
            begin
                repeat ($urandom_range(1, (wl == 0) ? 1 : wl))
                begin
                    add_req(REQ_TICK, NUM_SENSORS'($urandom));
                    n_rand++;
                end
            end
            phase++;
            if (phase % 7 == 0)
                add_req(REQ_DRAIN, 16'd0);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (tick_reqs.size() != 0 || sensor_valid)
            @(posedge clk);
        while (pending_bearings.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (pending_bearings.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_bearings.size()));

        $display("Run covered %0d ticks over %0d window-length writes; %0d bearings checked.",
                 n_ticks, n_cfg, n_checked);
        $display("Mismatches and stray results: %0d", err_cnt);
        if (err_cnt == 0)
            $display("[ir_ring_direction_integrator] OK");
        else
            $display("[ir_ring_direction_integrator] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/irdi_pkg.sv
hw/rtl/irdi_fifo.sv
hw/rtl/irdi_front.sv
hw/rtl/irdi_back.sv
hw/rtl/ir_ring_direction_integrator.sv
hw/rtl/irdi_checker.sv
tb/testbench.sv
